@@ src/utf8_two_byte_unicode_escaper_top_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-8 escaper assertion macros
// Assertion helpers shared by the escaper RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef UTF8_TWO_BYTE_UNICODE_ESCAPER_TOP_DEFINES_SVH
`define UTF8_TWO_BYTE_UNICODE_ESCAPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define UTE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequence must hold in the cycle after its antecedent.
`define UTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/ute_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 escaper package
// Widths, character constants, job type and hex digit helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ute_pkg;

	localparam int COUNT_WIDTH  = 16;
	localparam int CAP_WIDTH    = 16;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CP_WIDTH     = 11;

	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd256;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_PLAIN,
		JOB_ESCAPE
	} job_kind_t;

	// One unit of work for the back end: an optional body plus an optional NUL.
	typedef struct packed {
		job_kind_t             kind;
		logic [CP_WIDTH-1:0]   data;
		logic                  term;
	} job_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = CH_ZERO + {4'd0, v};
		end else begin
			r = CH_LOWER_A + {4'd0, v} - 8'd10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/ute_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 escaper channel interfaces
// Valid/ready channels for source bytes and escaped output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ute_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ute_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       is_terminator;

	modport source (output valid, output out_byte, output run_end, output is_terminator,
		input ready);
	modport sink   (input valid, input out_byte, input run_end, input is_terminator,
		output ready);
endinterface

`default_nettype wire

@@ src/utf8_two_byte_unicode_escaper_top.sv @@
// A transaction's output goes first into the job queue, then into the back end's output register.
// Throughput: one output byte per cycle while the receiver is ready, set by the single
// output register; a plain byte gives one byte, a two-byte pair six, and the NUL one more.
// Source bytes are taken every cycle while the two-entry job queue has room.
// Reset (arst_n low): capacity returns to 256, string state clears, queue and output empty.
// ----------------------------------------------------------------------------
// UTF-8 two-byte escaper top level
// Copies ASCII bytes and rewrites two-byte UTF-8 pairs as \uXXXX escapes,
// bounded by a programmable buffer capacity, closing each string with a NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_two_byte_unicode_escaper_top
	import ute_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ute_in_if.sink                    text,
	ute_out_if.source                 escaped,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CAP_WIDTH-1:0] cfg_wr_data
);

	// The front end classifies every accepted source byte against the string
	// state (held lead, byte count, halt flag) and the capacity register. Each
	// transaction that produces output becomes one job: a plain byte, an escape
	// of an eleven-bit code point, and/or a closing NUL.
	logic push;
	job_t push_job;
	logic full;

	// The back end drains jobs one output byte per cycle while the receiver is ready. The
	// queue lets the front end keep accepting while a long escape is still being written out.
	logic pop;
	job_t head_job;
	logic empty;

	ute_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.push_job    (push_job),
		.full        (full)
	);

	ute_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (head_job),
		.empty    (empty)
	);

	// The output register in the back end holds a waiting result, and the queue keeps taking
	// new source transactions behind it until the queue is full.
	ute_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (empty),
		.pop      (pop),
		.escaped  (escaped)
	);

endmodule

`default_nettype wire

@@ src/ute_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 escaper front end
// Accepts source bytes, tracks string state and room, and queues output jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ute_front
	import ute_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ute_in_if.sink                    text,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CAP_WIDTH-1:0] cfg_wr_data,
	output      logic                 push,
	output      job_t                 push_job,
	input  wire logic                 full
);

	localparam int LIM_W = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

	logic [CAP_WIDTH-1:0]   capacity_q;
	logic [4:0]             held_lead_q;
	logic                   lead_pending_q;
	logic [COUNT_WIDTH-1:0] bytes_written_q;
	logic                   halted_q;

	logic                   accept;
	logic [LIM_W-1:0]       cap_ext;
	logic [LIM_W-1:0]       mask_ext;
	logic [LIM_W-1:0]       lim;
	logic                   plain_room;
	logic                   esc_room;
	job_t                   job;
	logic                   hold_lead;
	logic                   set_halt;

	assign text.ready = !full;
	assign accept     = text.valid && text.ready;

	// The limit saturates at the largest count the counter can hold.
	always_comb begin
		cap_ext    = LIM_W'(capacity_q);
		mask_ext   = LIM_W'({COUNT_WIDTH{1'b1}});
		lim        = (cap_ext < mask_ext) ? cap_ext : mask_ext;
		plain_room = LIM_W'(bytes_written_q) < lim;
		esc_room   = ((LIM_W + 1)'(bytes_written_q) + (LIM_W + 1)'(6)) < (LIM_W + 1)'(lim);
	end

	always_comb begin
		job.kind  = JOB_NONE;
		job.data  = '0;
		job.term  = text.in_last;
		hold_lead = 1'b0;
		set_halt  = 1'b0;
		if (!halted_q) begin
			if (lead_pending_q) begin
				job.kind = JOB_ESCAPE;
				job.data = {held_lead_q, text.in_byte[5:0]};
			end else if (!text.in_byte[7]) begin
				if (plain_room) begin
					job.kind = JOB_PLAIN;
					job.data = CP_WIDTH'(text.in_byte);
				end else begin
					set_halt = 1'b1;
				end
			end else begin
				if (esc_room) begin
					hold_lead = 1'b1;
				end else begin
					set_halt = 1'b1;
				end
			end
		end
	end

	assign push     = accept && ((job.kind != JOB_NONE) || job.term);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q     <= '0;
			lead_pending_q  <= 1'b0;
			bytes_written_q <= '0;
			halted_q        <= 1'b0;
		end else if (accept) begin
			if (text.in_last) begin
				held_lead_q     <= '0;
				lead_pending_q  <= 1'b0;
				bytes_written_q <= '0;
				halted_q        <= 1'b0;
			end else begin
				if (job.kind == JOB_ESCAPE) begin
					lead_pending_q  <= 1'b0;
					held_lead_q     <= '0;
					bytes_written_q <= bytes_written_q + COUNT_WIDTH'(6);
				end else if (job.kind == JOB_PLAIN) begin
					bytes_written_q <= bytes_written_q + COUNT_WIDTH'(1);
				end
				if (hold_lead) begin
					held_lead_q    <= text.in_byte[4:0];
					lead_pending_q <= 1'b1;
				end
				if (set_halt) begin
					halted_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/ute_fifo.sv @@
// ----------------------------------------------------------------------------
// UTF-8 escaper job queue
// Short queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_two_byte_unicode_escaper_top_defines.svh"

module ute_fifo
	import ute_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output      logic full,
	input  wire logic pop,
	output      job_t pop_job,
	output      logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`UTE_ASSERT(a_no_overflow, clk, arst_n, !(push && full), "job queue written while full")
	`UTE_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "job queue read while empty")
	`UTE_ASSERT_NEXT(a_count_push, clk, arst_n, push && !pop, count_q == $past(count_q) + CNT_W'(1), "queue count did not follow a push")

endmodule

`default_nettype wire

@@ src/ute_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 escaper back end
// Expands queued jobs into output bytes, one per cycle while the receiver is ready, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ute_back
	import ute_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head_job,
	input  wire logic empty,
	output      logic pop,
	ute_out_if.source escaped
);

	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_end_q;
	logic        is_term_q;

	logic        load;
	logic [2:0]  body_len;
	logic [2:0]  total_len;
	logic        last_step;
	logic        in_body;
	logic [15:0] cp;
	logic [7:0]  body_byte;
	logic [7:0]  next_byte;

	always_comb begin
		case (head_job.kind)
			JOB_PLAIN:  body_len = 3'd1;
			JOB_ESCAPE: body_len = 3'd6;
			default:    body_len = 3'd0;
		endcase
		total_len = body_len + {2'b00, head_job.term};
		last_step = step_q == (total_len - 3'd1);
		in_body   = step_q < body_len;
		cp        = 16'(head_job.data);
	end

	always_comb begin
		if (head_job.kind == JOB_PLAIN) begin
			body_byte = head_job.data[7:0];
		end else begin
			case (step_q)
				3'd0:    body_byte = CH_BACKSLASH;
				3'd1:    body_byte = CH_LOWER_U;
				3'd2:    body_byte = hex_digit(cp[15:12]);
				3'd3:    body_byte = hex_digit(cp[11:8]);
				3'd4:    body_byte = hex_digit(cp[7:4]);
				default: body_byte = hex_digit(cp[3:0]);
			endcase
		end
		next_byte = in_body ? body_byte : CH_NUL;
	end

	assign load = !empty && (!out_valid_q || escaped.ready);
	assign pop  = load && last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_step ? 3'd0 : step_q + 3'd1;
			end else if (escaped.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_end_q  <= last_step;
			is_term_q  <= !in_body;
		end
	end

	assign escaped.valid         = out_valid_q;
	assign escaped.out_byte      = out_byte_q;
	assign escaped.run_end       = run_end_q;
	assign escaped.is_terminator = is_term_q;

endmodule

`default_nettype wire

@@ sim/ute_escape_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 escaper checker
// Watches the source, output and capacity ports, predicts the escaped byte
// stream for every source transaction and compares it with what comes out.
// ----------------------------------------------------------------------------

module ute_escape_checker
	import ute_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ute_in_if                    text,
	ute_out_if                   escaped,
	input  logic                 cfg_wr_en,
	input  logic [CAP_WIDTH-1:0] cfg_wr_data,
	output int                   fail_count,
	output int                   chars_due
);

	typedef struct packed {
		logic [7:0] code;
		logic       run_end;
		logic       term;
	} escaped_char_t;

	localparam logic [8*16-1:0] HEX_CHARS = "0123456789abcdef";
	localparam int MAX_PRINTED = 100;

	logic [CAP_WIDTH-1:0]   capacity;
	logic [7:0]             held_lead;
	logic                   lead_pending;
	logic [COUNT_WIDTH-1:0] bytes_written;
	logic                   halted;
	escaped_char_t          escaped_due[$];
	int                     fails = 0;
	int                     due_count = 0;

	assign fail_count = fails;
	assign chars_due  = due_count;

	function automatic logic [7:0] hex_char(input logic [3:0] nibble);
		return HEX_CHARS[8*(15-nibble) +: 8];
	endfunction

	task automatic report_mismatch(input string what);
		fails++;
		if (fails <= MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// Works out every byte that one source byte causes and queues them in order.
	task automatic predict_escape(input logic [7:0] src, input logic last);
		escaped_char_t burst[7];
		logic [15:0]   point;
		logic [47:0]   escape_codes;
		int            n;
		n = 0;
		if (!halted) begin
			if (lead_pending) begin
				// The follower completes the pair whatever its value.
				point = {5'd0, held_lead[4:0], src[5:0]};
				escape_codes = {CH_BACKSLASH, CH_LOWER_U, hex_char(point[15:12]),
					hex_char(point[11:8]), hex_char(point[7:4]), hex_char(point[3:0])};
				for (int k = 0; k < 6; k++) begin
					burst[n] = '{code: escape_codes[47-8*k -: 8], run_end: 1'b0, term: 1'b0};
					n++;
				end
				lead_pending  = 1'b0;
				held_lead     = '0;
				bytes_written = bytes_written + COUNT_WIDTH'(6);
			end else if (src < 8'h80) begin
				if (bytes_written < capacity) begin
					burst[n] = '{code: src, run_end: 1'b0, term: 1'b0};
					n++;
					bytes_written = bytes_written + COUNT_WIDTH'(1);
				end else begin
					halted = 1'b1;
				end
			end else if (int'(bytes_written) + 6 < int'(capacity)) begin
				held_lead    = src;
				lead_pending = 1'b1;
			end else begin
				halted = 1'b1;
			end
		end
		if (last) begin
			burst[n] = '{code: CH_NUL, run_end: 1'b0, term: 1'b1};
			n++;
			held_lead     = '0;
			lead_pending  = 1'b0;
			bytes_written = '0;
			halted        = 1'b0;
		end
		if (n > 0) begin
			burst[n-1].run_end = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			escaped_due.push_back(burst[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		escaped_char_t want;
		if (!arst_n) begin
			capacity      = CAP_RESET;
			held_lead     = '0;
			lead_pending  = 1'b0;
			bytes_written = '0;
			halted        = 1'b0;
			escaped_due.delete();
		end else begin
			if (cfg_wr_en) begin
				capacity = cfg_wr_data;
			end
			if (text.valid && text.ready) begin
				predict_escape(text.in_byte, text.in_last);
			end
			if (escaped.valid && escaped.ready) begin
				if (escaped_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", escaped.out_byte));
				end else begin
					want = escaped_due.pop_front();
					if (escaped.out_byte !== want.code) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							escaped.out_byte, want.code));
					end
					if (escaped.run_end !== want.run_end) begin
						report_mismatch($sformatf("run_end %b, expected %b on byte %02h",
							escaped.run_end, want.run_end, want.code));
					end
					if (escaped.is_terminator !== want.term) begin
						report_mismatch($sformatf("is_terminator %b, expected %b on byte %02h",
							escaped.is_terminator, want.term, want.code));
					end
				end
			end
		end
		due_count = escaped_due.size();
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 escaper testbench
// Drives strings of source bytes through the escaper under several buffer
// capacities and traffic patterns; a checker beside the block predicts and
// compares every output transaction.
// ----------------------------------------------------------------------------

module tb;
	import ute_pkg::*;

	// Only a hung block ever reaches this cycle limit.
	localparam int CYCLE_LIMIT = 200000;
	// A source byte that causes no output is never queued and only updates the front end's
	// string state; this wait lets the block settle after the last expected byte comes out.
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS = 45;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CAP_WIDTH-1:0] cfg_wr_data = '0;

	int fail_count;
	int chars_due;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	int cycle_count = 0;

	ute_in_if  text();
	ute_out_if escaped();

	utf8_two_byte_unicode_escaper_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.escaped     (escaped),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	ute_escape_checker u_escape_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.escaped     (escaped),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.chars_due   (chars_due)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random while a stall percentage is set; with zero
	// it takes every output transaction as soon as it is offered.
	always @(posedge clk) begin
		if (!arst_n) begin
			escaped.ready <= 1'b0;
		end else begin
			escaped.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: a block that stops moving data ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one source byte and returns at the edge where it is accepted. Valid
	// is only lowered here inside an idle gap, so back-to-back transactions keep it high.
	task automatic send_byte(input logic [7:0] src, input logic last);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid   <= 1'b1;
		text.in_byte <= src;
		text.in_last <= last;
		do @(posedge clk); while (!text.ready);
		items_sent++;
	endtask

	// Stops the sender and waits until every predicted byte has come out, then
	// lets the block settle on any bytes that produce nothing.
	task automatic wait_drained();
		text.valid <= 1'b0;
		@(posedge clk);
		while (chars_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The capacity register is only written while the block is idle.
	task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Traffic patterns: none, sender idles, receiver stalls, both idling less often.
	task automatic set_traffic(input int pattern);
		case (pattern)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 62;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 62;
			end
			default: begin
				src_idle_pct   = 31;
				sink_stall_pct = 31;
			end
		endcase
	endtask

	// One string of mostly well-formed text: ASCII, proper two-byte pairs, and
	// some arbitrary bytes. A pair cut by the end of the string leaves a lead on
	// the last byte, which the block must drop. Now and then a long string runs
	// into a small capacity and halts.
	task automatic send_random_string();
		int len;
		int pos;
		int pick;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
		pos = 0;
		while (pos < len) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_byte(8'($urandom_range(127)), pos == len - 1);
				pos++;
			end else if (pick < 80) begin
				send_byte(8'($urandom_range(255, 128)), pos == len - 1);
				pos++;
				if (pos < len) begin
					send_byte(8'($urandom_range(191, 128)), pos == len - 1);
					pos++;
				end
			end else begin
				send_byte(8'($urandom_range(255)), pos == len - 1);
				pos++;
			end
		end
	endtask

	initial begin
		logic [CAP_WIDTH-1:0] phase_caps[8];
		logic [CAP_WIDTH-1:0] cap;
		int                   phase_end;
		int                   strings;

		phase_caps = '{16'd1, 16'd65535, 16'd2, 16'd7, 16'd8, 16'd20, 16'd0, 16'd256};

		text.valid    = 1'b0;
		text.in_byte  = '0;
		text.in_last  = 1'b0;
		escaped.ready = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity of 256, no idling.
		set_traffic(0);
		send_byte(8'h00, 1'b0);  // smallest plain byte
		send_byte(8'h7F, 1'b0);  // largest plain byte
		send_byte(8'h41, 1'b0);
		send_byte(8'hC3, 1'b0);  // ordinary pair
		send_byte(8'hA9, 1'b0);
		send_byte(8'hFF, 1'b0);  // largest code point
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);  // smallest lead, follower below 0x80
		send_byte(8'h00, 1'b0);
		send_byte(8'hD0, 1'b0);  // pair whose follower ends the string
		send_byte(8'h90, 1'b1);
		send_byte(8'hC5, 1'b1);  // a lead that ends the string is dropped
		send_byte(8'h00, 1'b1);  // a string of just a NUL byte
		send_byte(8'h55, 1'b1);

		// Capacity 7: a pair just fits, one plain byte after it, then halt.
		write_capacity(16'd7);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h7E, 1'b1);

		// Capacity 6: a lead with no room halts at once and is not held, so its
		// follower is consumed silently.
		write_capacity(16'd6);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);

		// Capacity 1: one plain byte fits, the rest of the string is swallowed.
		write_capacity(16'd1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);

		// Random part: one phase per capacity, each with one of the four traffic patterns in turn.
		// Every sixth string the sender holds off until the output has drained.
		for (int p = 0; p < 8; p++) begin
			cap = (p == 6) ? CAP_WIDTH'($urandom_range(65535, 1)) : phase_caps[p];
			write_capacity(cap);
			set_traffic(p % 4);
			phase_end = items_sent + PHASE_ITEMS;
			strings = 0;
			while (items_sent < phase_end) begin
				send_random_string();
				strings++;
				if (strings % 6 == 0) begin
					wait_drained();
				end
			end
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
